@@ src/twce_pkg.sv @@
// Package for the text window cursor engine: microcode types, codes and the control store.
package twce_pkg;

    // Blank cells written by a tab
    localparam logic [15:0] TAB_CELLS = 16'd4;

    // Character codes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_BLANK = 8'h20;

    // Result command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_COPY  = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ATTR   = 2'd3;

    // Remainder unit: one dividend bit per step
    localparam int          DIV_BITS     = 16;
    localparam logic [3:0]  DIV_LAST_CNT = 4'(DIV_BITS - 1);

    typedef logic [4:0] step_t;
    typedef logic [3:0] op_t;
    typedef logic [2:0] br_t;
    typedef logic [2:0] emit_t;

    // Datapath operations
    localparam op_t OP_NONE     = 4'd0;
    localparam op_t OP_MUL      = 4'd1;   // cells = width * height
    localparam op_t OP_END      = 4'd2;   // end = base + cells - 1
    localparam op_t OP_DIV_INIT = 4'd3;   // load cursor - base into the remainder unit
    localparam op_t OP_DIV_STEP = 4'd4;   // one restoring remainder step
    localparam op_t OP_CR       = 4'd5;
    localparam op_t OP_NL       = 4'd6;
    localparam op_t OP_TAB      = 4'd7;
    localparam op_t OP_BS       = 4'd8;
    localparam op_t OP_PRINT    = 4'd9;
    localparam op_t OP_CLEAR    = 4'd10;
    localparam op_t OP_HOLD     = 4'd11;  // new cursor = cursor
    localparam op_t OP_COMMIT   = 4'd12;  // cursor = new cursor

    // Sequencing
    localparam br_t BR_NEXT        = 3'd0;
    localparam br_t BR_GOTO        = 3'd1;
    localparam br_t BR_DISPATCH    = 3'd2;
    localparam br_t BR_LOOP        = 3'd3;
    localparam br_t BR_EMIT        = 3'd4;
    localparam br_t BR_SKIP_BS     = 3'd5;  // jump when cursor is not above base
    localparam br_t BR_SKIP_SCROLL = 3'd6;  // jump when cursor is not past end

    // Result kinds
    localparam emit_t EM_NONE  = 3'd0;
    localparam emit_t EM_CLEAR = 3'd1;
    localparam emit_t EM_TAB   = 3'd2;
    localparam emit_t EM_BS    = 3'd3;
    localparam emit_t EM_COPY  = 3'd4;
    localparam emit_t EM_ROW   = 3'd5;
    localparam emit_t EM_CHAR  = 3'd6;

    typedef struct packed {
        op_t   op;
        br_t   br;
        emit_t emit;
        step_t target;
    } ucode_t;

    // Program addresses
    localparam step_t S_IDLE   = 5'd0;
    localparam step_t S_C_MUL  = 5'd1;
    localparam step_t S_C_SET  = 5'd2;
    localparam step_t S_C_EMIT = 5'd3;
    localparam step_t S_C_DONE = 5'd4;
    localparam step_t S_R_INIT = 5'd5;
    localparam step_t S_R_STEP = 5'd6;
    localparam step_t S_R_SET  = 5'd7;
    localparam step_t S_R_DONE = 5'd8;
    localparam step_t S_N_INIT = 5'd9;
    localparam step_t S_N_STEP = 5'd10;
    localparam step_t S_N_SET  = 5'd11;
    localparam step_t S_N_DONE = 5'd12;
    localparam step_t S_T_SET  = 5'd13;
    localparam step_t S_T_EMIT = 5'd14;
    localparam step_t S_T_DONE = 5'd15;
    localparam step_t S_B_TEST = 5'd16;
    localparam step_t S_B_SET  = 5'd17;
    localparam step_t S_B_EMIT = 5'd18;
    localparam step_t S_B_DONE = 5'd19;
    localparam step_t S_P_MUL  = 5'd20;
    localparam step_t S_P_END  = 5'd21;
    localparam step_t S_P_SET  = 5'd22;
    localparam step_t S_P_COPY = 5'd23;
    localparam step_t S_P_FILL = 5'd24;
    localparam step_t S_P_CHAR = 5'd25;
    localparam step_t S_P_DONE = 5'd26;
    localparam step_t S_LAST   = S_P_DONE;

    // Control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '{op: OP_NONE, br: BR_GOTO, emit: EM_NONE, target: S_IDLE};
        unique case (step)
            S_IDLE:   w = '{OP_NONE,     BR_DISPATCH,    EM_NONE,  S_IDLE};
            // clear window
            S_C_MUL:  w = '{OP_MUL,      BR_NEXT,        EM_NONE,  S_IDLE};
            S_C_SET:  w = '{OP_CLEAR,    BR_NEXT,        EM_NONE,  S_IDLE};
            S_C_EMIT: w = '{OP_NONE,     BR_EMIT,        EM_CLEAR, S_IDLE};
            S_C_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            // carriage return
            S_R_INIT: w = '{OP_DIV_INIT, BR_NEXT,        EM_NONE,  S_IDLE};
            S_R_STEP: w = '{OP_DIV_STEP, BR_LOOP,        EM_NONE,  S_IDLE};
            S_R_SET:  w = '{OP_CR,       BR_NEXT,        EM_NONE,  S_IDLE};
            S_R_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            // newline
            S_N_INIT: w = '{OP_DIV_INIT, BR_NEXT,        EM_NONE,  S_IDLE};
            S_N_STEP: w = '{OP_DIV_STEP, BR_LOOP,        EM_NONE,  S_IDLE};
            S_N_SET:  w = '{OP_NL,       BR_NEXT,        EM_NONE,  S_IDLE};
            S_N_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            // tab
            S_T_SET:  w = '{OP_TAB,      BR_NEXT,        EM_NONE,  S_IDLE};
            S_T_EMIT: w = '{OP_NONE,     BR_EMIT,        EM_TAB,   S_IDLE};
            S_T_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            // backspace
            S_B_TEST: w = '{OP_HOLD,     BR_SKIP_BS,     EM_NONE,  S_B_DONE};
            S_B_SET:  w = '{OP_BS,       BR_NEXT,        EM_NONE,  S_IDLE};
            S_B_EMIT: w = '{OP_NONE,     BR_EMIT,        EM_BS,    S_IDLE};
            S_B_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            // printable byte, with scroll when past the end
            S_P_MUL:  w = '{OP_MUL,      BR_NEXT,        EM_NONE,  S_IDLE};
            S_P_END:  w = '{OP_END,      BR_NEXT,        EM_NONE,  S_IDLE};
            S_P_SET:  w = '{OP_PRINT,    BR_SKIP_SCROLL, EM_NONE,  S_P_CHAR};
            S_P_COPY: w = '{OP_NONE,     BR_EMIT,        EM_COPY,  S_IDLE};
            S_P_FILL: w = '{OP_NONE,     BR_EMIT,        EM_ROW,   S_IDLE};
            S_P_CHAR: w = '{OP_NONE,     BR_EMIT,        EM_CHAR,  S_IDLE};
            S_P_DONE: w = '{OP_COMMIT,   BR_GOTO,        EM_NONE,  S_IDLE};
            default:  w = '{OP_NONE,     BR_GOTO,        EM_NONE,  S_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ src/text_window_cursor_engine.sv @@
// Text window cursor engine: microcoded sequencer, cursor datapath and result register.
// Usage:
//   Input requests arrive on s_tvalid/s_tready: s_tuser selects clear window (1) or put
//   byte (0), s_tdata carries the byte. Each request yields zero to three cell commands on
//   m_tvalid/m_tready; m_tuser holds the command, m_tdata the cell fields, m_tlast marks the
//   final command of that request. The user must write window registers (cfg_wr_en/cfg_index/
//   cfg_wdata) only while idle; the block does not check this. A base write homes the cursor.
// Timing:
//   A 5-bit step counter walks a control store, one step per cycle except while an emit
//   step waits for a free result register. An ignored byte goes straight back to idle, a
//   backspace at the window base skips to its commit step, and a printable byte that
//   scrolls emits a copy and a row fill before its character. The column for carriage
//   return and newline comes from a restoring remainder unit that takes one dividend bit
//   per cycle. Each command is loaded by its emit step when the result register is free.
// Reset and stall:
//   aresetn (synchronous, active low) restores base 0, width 80, height 25, attribute 7,
//   cursor 0, and empties the result register. When the receiver holds m_tready low, the
//   result register keeps its command and the sequencer waits on its next emit step; the
//   next request is taken after the commit step that follows the last command.
module text_window_cursor_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // [0] action
    // Cell commands
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] cell_offset, [31:16] cell_count,
                                   // [39:32] cell_char, [47:40] cell_attribute,
                                   // [63:48] cursor_after
    output logic [1:0]  m_tuser,   // [1:0] command
    output logic        m_tlast
);
    import twce_pkg::*;

    // Sequencer state
    step_t      step_reg, step_next;
    logic [3:0] cnt_reg, cnt_next;
    ucode_t     uw;

    // Window registers
    logic [15:0] base_reg, base_next;
    logic [7:0]  width_reg, width_next;
    logic [7:0]  height_reg, height_next;
    logic [7:0]  attr_reg, attr_next;

    // Datapath registers
    logic [15:0] cur_reg, cur_next;
    logic [15:0] nxt_reg, nxt_next;
    logic [15:0] cells_reg, cells_next;
    logic [15:0] end_reg, end_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  char_reg, char_next;

    // Result register
    logic        mvalid_reg, mvalid_next;
    logic [1:0]  mcmd_reg, mcmd_next;
    logic [15:0] moff_reg, moff_next;
    logic [15:0] mcnt_reg, mcnt_next;
    logic [7:0]  mchar_reg, mchar_next;
    logic [7:0]  mattr_reg, mattr_next;
    logic [15:0] mcur_reg, mcur_next;
    logic        mlast_reg, mlast_next;

    // Helpers
    logic [8:0]  trial;
    logic [7:0]  col;
    logic [15:0] row_start;
    logic        out_free;
    logic        scroll;
    logic        bs_ok;
    logic        accept;
    step_t       entry;
    logic [7:0]  in_char;
    logic        in_clear;

    assign uw       = ucode_rom(step_reg);
    assign in_clear = s_tuser;
    assign in_char  = s_tdata;
    assign s_tready = (step_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    assign trial     = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign col       = (width_reg == 8'd0) ? 8'd0 : rem_reg;
    assign row_start = end_reg - {8'd0, width_reg} + 16'd1;
    assign scroll    = cur_reg > end_reg;
    assign bs_ok     = cur_reg > base_reg;

    // Entry point by request kind
    always_comb begin
        if (in_clear) begin
            entry = S_C_MUL;
        end else begin
            unique case (in_char)
                CHAR_CR:  entry = S_R_INIT;
                CHAR_LF:  entry = S_N_INIT;
                CHAR_TAB: entry = S_T_SET;
                CHAR_BS:  entry = S_B_TEST;
                default:  entry = (!in_char[7] && in_char[6:5] != 2'b00) ? S_P_MUL : S_IDLE;
            endcase
        end
    end

    // Step counter and branches
    always_comb begin
        step_next = step_reg;
        cnt_next  = cnt_reg;
        unique case (uw.br)
            BR_NEXT:     step_next = step_reg + 5'd1;
            BR_GOTO:     step_next = uw.target;
            BR_DISPATCH: begin
                if (s_tvalid) begin
                    step_next = entry;
                end
            end
            BR_LOOP: begin
                if (cnt_reg != 4'd0) begin
                    cnt_next = cnt_reg - 4'd1;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            BR_EMIT: begin
                if (out_free) begin
                    step_next = step_reg + 5'd1;
                end
            end
            BR_SKIP_BS:     step_next = bs_ok ? step_reg + 5'd1 : uw.target;
            BR_SKIP_SCROLL: step_next = scroll ? step_reg + 5'd1 : uw.target;
            default:        step_next = S_IDLE;
        endcase
        if (uw.op == OP_DIV_INIT) begin
            cnt_next = DIV_LAST_CNT;
        end
    end

    // Datapath operations and configuration writes
    always_comb begin
        base_next   = base_reg;
        width_next  = width_reg;
        height_next = height_reg;
        attr_next   = attr_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        cells_next  = cells_reg;
        end_next    = end_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        char_next   = accept ? in_char : char_reg;

        unique case (uw.op)
            OP_NONE:     ;
            OP_MUL:      cells_next = {8'd0, width_reg} * {8'd0, height_reg};
            OP_END:      end_next = base_reg + cells_reg - 16'd1;
            OP_DIV_INIT: begin
                dvd_next = cur_reg - base_reg;
                rem_next = 8'd0;
            end
            OP_DIV_STEP: begin
                dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
                if (trial >= {1'b0, width_reg}) begin
                    rem_next = 8'(trial - {1'b0, width_reg});
                end else begin
                    rem_next = trial[7:0];
                end
            end
            OP_CR:     nxt_next = cur_reg - {8'd0, col};
            OP_NL:     nxt_next = cur_reg + {8'd0, 8'(width_reg - col)};
            OP_TAB:    nxt_next = cur_reg + TAB_CELLS;
            OP_BS:     nxt_next = cur_reg - 16'd1;
            OP_PRINT:  nxt_next = (scroll ? row_start : cur_reg) + 16'd1;
            OP_CLEAR:  nxt_next = base_reg;
            OP_HOLD:   nxt_next = cur_reg;
            OP_COMMIT: cur_next = nxt_reg;
            default:   ;
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BASE: begin
                    base_next = cfg_wdata;
                    cur_next  = cfg_wdata;
                end
                REG_WIDTH:  width_next  = cfg_wdata[7:0];
                REG_HEIGHT: height_next = cfg_wdata[7:0];
                REG_ATTR:   attr_next   = cfg_wdata[7:0];
                default:    ;
            endcase
        end
    end

    // Result register load
    always_comb begin
        mvalid_next = mvalid_reg && !m_tready;
        mcmd_next   = mcmd_reg;
        moff_next   = moff_reg;
        mcnt_next   = mcnt_reg;
        mchar_next  = mchar_reg;
        mattr_next  = mattr_reg;
        mcur_next   = mcur_reg;
        mlast_next  = mlast_reg;
        if (uw.br == BR_EMIT && out_free) begin
            mvalid_next = 1'b1;
            mcur_next   = nxt_reg;
            mchar_next  = CHAR_BLANK;
            mattr_next  = attr_reg;
            mlast_next  = 1'b1;
            unique case (uw.emit)
                EM_CLEAR: begin
                    mcmd_next = CMD_FILL;
                    moff_next = base_reg;
                    mcnt_next = cells_reg;
                end
                EM_TAB: begin
                    mcmd_next = CMD_FILL;
                    moff_next = cur_reg;
                    mcnt_next = TAB_CELLS;
                end
                EM_BS: begin
                    mcmd_next = CMD_WRITE;
                    moff_next = nxt_reg;
                    mcnt_next = 16'd1;
                end
                EM_COPY: begin
                    mcmd_next  = CMD_COPY;
                    moff_next  = base_reg + {8'd0, width_reg};
                    mcnt_next  = (height_reg == 8'd0) ? 16'd0 : cells_reg - {8'd0, width_reg};
                    mchar_next = 8'd0;
                    mattr_next = 8'd0;
                    mlast_next = 1'b0;
                end
                EM_ROW: begin
                    mcmd_next  = CMD_FILL;
                    moff_next  = row_start;
                    mcnt_next  = {8'd0, width_reg};
                    mlast_next = 1'b0;
                end
                default: begin
                    mcmd_next  = CMD_WRITE;
                    moff_next  = nxt_reg - 16'd1;
                    mcnt_next  = 16'd1;
                    mchar_next = char_reg;
                end
            endcase
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= S_IDLE;
            cnt_reg    <= 4'd0;
            base_reg   <= 16'd0;
            width_reg  <= 8'd80;
            height_reg <= 8'd25;
            attr_reg   <= 8'd7;
            cur_reg    <= 16'd0;
            mvalid_reg <= 1'b0;
        end else begin
            step_reg   <= step_next;
            cnt_reg    <= cnt_next;
            base_reg   <= base_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            attr_reg   <= attr_next;
            cur_reg    <= cur_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nxt_reg   <= nxt_next;
        cells_reg <= cells_next;
        end_reg   <= end_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        char_reg  <= char_next;
        mcmd_reg  <= mcmd_next;
        moff_reg  <= moff_next;
        mcnt_reg  <= mcnt_next;
        mchar_reg <= mchar_next;
        mattr_reg <= mattr_next;
        mcur_reg  <= mcur_next;
        mlast_reg <= mlast_next;
    end

    // Outputs
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = mcmd_reg;
    assign m_tdata  = {mcur_reg, mattr_reg, mchar_reg, mcnt_reg, moff_reg};

`ifndef SYNTHESIS
    // Only copy-back and row fill come before the final command of a request
    a_nonlast_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !mlast_reg) |-> (mcmd_reg == CMD_COPY || mcmd_reg == CMD_FILL))
        else $error("non-final command is neither copy nor fill");

    // A single-cell write always moves exactly one cell
    a_write_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && mcmd_reg == CMD_WRITE) |-> (mcnt_reg == 16'd1))
        else $error("write command with count other than one");

    // Cursor moves only on commit steps or a configuration write
    a_cursor_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op != OP_COMMIT && !cfg_wr_en) |=> $stable(cur_reg))
        else $error("cursor changed outside commit");

    // Step counter stays inside the program
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= S_LAST)
        else $error("step counter past end of program");

    // Remainder loop counter is only busy in the remainder steps
    a_loop_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 4'd0) |-> (step_reg == S_R_STEP || step_reg == S_N_STEP))
        else $error("loop counter active outside remainder steps");
`endif

endmodule
